### hdl/dfem_pkg.sv
package dfem_pkg;

   localparam int DEST_X_W   = 12;
   localparam int DEST_Y_W   = 11;
   localparam int OUT_W      = 20;
   localparam int IMG_W_W    = 13;
   localparam int SCALE_W    = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam int DW         = 34;
   localparam int ANG_W      = 32;
   localparam int STEPS      = 28;

   localparam int DIV_BITS      = DEST_X_W + ANG_W;
   localparam int DIV_PER_STAGE = 4;
   localparam int DIV_STAGES    = DIV_BITS / DIV_PER_STAGE;

   localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 13'd1280;
   localparam logic [SCALE_W-1:0] RADIUS_SCALE_RESET = 16'd57934;

   localparam logic signed [DW-1:0] GAIN_Q30     = 34'sd652032874;
   localparam logic signed [DW-1:0] HALF_TURN    = 34'sh080000000;
   localparam logic signed [DW-1:0] QUARTER_TURN = 34'sh040000000;

   localparam logic [ANG_W-1:0] ANG_HALF     = 32'h80000000;
   localparam logic [ANG_W-1:0] ANG_QUARTER  = 32'h40000000;
   localparam logic [ANG_W-1:0] ANG_3QUARTER = 32'hC0000000;

   localparam logic [OUT_W-1:0] OUT_MAX = 20'hFFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_RADIUS_SCALE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [OUT_W-1:0] src_x;
      logic [OUT_W-1:0] src_y;
      logic             lens_select;
   } rsp_type;

   function automatic logic signed [DW-1:0] atan_turn(input int i);
      logic signed [DW-1:0] v;
      case (i)
         0:  v = 34'sh020000000;
         1:  v = 34'sh012E4051E;
         2:  v = 34'sh009FB385B;
         3:  v = 34'sh0051111D4;
         4:  v = 34'sh0028B0D43;
         5:  v = 34'sh00145D7E1;
         6:  v = 34'sh000A2F61E;
         7:  v = 34'sh000517C55;
         8:  v = 34'sh00028BE53;
         9:  v = 34'sh000145F2F;
         10: v = 34'sh0000A2F98;
         11: v = 34'sh0000517CC;
         12: v = 34'sh000028BE6;
         13: v = 34'sh0000145F3;
         14: v = 34'sh00000A2FA;
         15: v = 34'sh00000517D;
         16: v = 34'sh0000028BE;
         17: v = 34'sh00000145F;
         18: v = 34'sh000000A30;
         19: v = 34'sh000000518;
         20: v = 34'sh00000028C;
         21: v = 34'sh000000146;
         22: v = 34'sh0000000A3;
         23: v = 34'sh000000051;
         24: v = 34'sh000000029;
         25: v = 34'sh000000014;
         26: v = 34'sh00000000A;
         27: v = 34'sh000000005;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

### hdl/dfem_if.sv
interface dfem_req_if import dfem_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [DEST_X_W-1:0] dest_x;
   logic [DEST_Y_W-1:0] dest_y;
   modport source(output valid, dest_x, dest_y, input ready);
   modport sink(input valid, dest_x, dest_y, output ready);
endinterface

interface dfem_rsp_if import dfem_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [OUT_W-1:0] src_x;
   logic [OUT_W-1:0] src_y;
   logic             lens_select;
   modport source(output valid, src_x, src_y, lens_select, input ready);
   modport sink(input valid, src_x, src_y, lens_select, output ready);
endinterface

interface dfem_csr_if import dfem_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

### hdl/dual_fisheye_equirect_map.sv
// Dual-fisheye to equirectangular coordinate map.
//
// req_ch carries one panorama pixel (dest_x, dest_y) per transfer; rsp_ch
// returns one source coordinate (src_x, src_y in unsigned Q12.FRAC_BITS,
// lens_select) per request, in request order. csr_ch writes image_width
// (index 0) and radius_scale (index 1); it is always ready and must only be
// written while no request is in flight.
//
// Throughput: one request per cycle unless the output buffer is full. A request
// passes through the input register, a pipelined 4-bit-per-stage divider
// (11 stages), three 30-stage CORDIC sections (sin/cos of the
// angles, atan2 for th2, atan2 for ph2 alongside sin/cos of th2) and the
// multiply and output stages before it reaches the output buffer.
//
// Reset clears all valid bits and the two-entry output buffer and restores
// image_width 1280, radius_scale 57934. When rsp_ch stalls, results collect
// in the output buffer; req_ch.ready drops only once both entries are full,
// and the whole pipeline then holds in place.
module dual_fisheye_equirect_map import dfem_pkg::*; #(
   parameter int MAX_WIDTH = 4096,
   parameter int FRAC_BITS = 8
) (
   input logic         clock,
   input logic         reset,
   dfem_req_if.sink    req_ch,
   dfem_rsp_if.source  rsp_ch,
   dfem_csr_if.sink    csr_ch
);

   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int RQ_W  = SCALE_W + WW;
   localparam int TW    = RQ_W + 1;
   localparam int PW    = TW + 1 + DW;
   localparam int SHIFT = 48 - FRAC_BITS;
   localparam int CW    = WW + FRAC_BITS;
   localparam int SW    = (CW + 3 > OUT_W + 2) ? CW + 3 : OUT_W + 2;

   logic [IMG_W_W-1:0] w_ff;
   logic [SCALE_W-1:0] rs_ff;
   logic [WW-1:0]      w_eff;
   logic [RQ_W-1:0]    rq_ff;
   logic               en;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff  <= IMAGE_WIDTH_RESET;
         rs_ff <= RADIUS_SCALE_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            CSR_IMAGE_WIDTH:  w_ff  <= csr_ch.data[IMG_W_W-1:0];
            CSR_RADIUS_SCALE: rs_ff <= csr_ch.data[SCALE_W-1:0];
         endcase
      end
   end

   always_comb begin
      if (w_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(w_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(w_ff);
      end
   end

   always_ff @(posedge clock) begin
      rq_ff <= RQ_W'(rs_ff) * RQ_W'(w_eff);
   end

   // input register
   logic                in_vld_ff;
   logic [DEST_X_W-1:0] dx_ff;
   logic [DEST_Y_W-1:0] dy_ff;

   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (en) begin
         in_vld_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff <= req_ch.dest_x;
         dy_ff <= req_ch.dest_y;
      end
   end

   // angles
   logic             div_vld;
   logic [ANG_W-1:0] lon, lat;

   dfem_div #(.DIV_W(WW)) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_vld_ff),
      .in_num_x  (dx_ff),
      .in_num_y  (DEST_X_W'(dy_ff)),
      .divisor   (w_eff),
      .out_valid (div_vld),
      .out_quo_x (lon),
      .out_quo_y (lat)
   );

   logic                 sc_vld;
   logic signed [DW-1:0] cl, sl, ct, st;

   dfem_cordic #(.VECTOR(1'b0), .TAG_W(1)) u_sc_lon (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_vld),
      .in_x      (GAIN_Q30),
      .in_y      ('0),
      .in_z      (DW'($signed(lon))),
      .in_tag    (1'b0),
      .out_valid (sc_vld),
      .out_x     (cl),
      .out_y     (sl),
      .out_z     (),
      .out_tag   ()
   );

   dfem_cordic #(.VECTOR(1'b0), .TAG_W(1)) u_sc_lat (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (div_vld),
      .in_x      (GAIN_Q30),
      .in_y      ('0),
      .in_z      (DW'($signed(lat))),
      .in_tag    (1'b0),
      .out_valid (),
      .out_x     (ct),
      .out_y     (st),
      .out_z     (),
      .out_tag   ()
   );

   // unit ray
   logic                   m1_vld_ff;
   logic signed [DW-1:0]   x1_ff, y1_ff, z_ff;
   logic signed [2*DW-1:0] px1, py1;

   assign px1 = (2*DW)'(st) * (2*DW)'(cl);
   assign py1 = (2*DW)'(st) * (2*DW)'(sl);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else if (en) begin
         m1_vld_ff <= sc_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= px1[30 +: DW];
         y1_ff <= py1[30 +: DW];
         z_ff  <= ct;
      end
   end

   // th2 = atan2(y1, -z)
   logic                 degen;
   logic                 v1_vld;
   logic signed [DW-1:0] v1_mag, v1_ang;
   logic [DW:0]          v1_tag;

   assign degen = (y1_ff == '0) && (z_ff == '0);

   dfem_cordic #(.VECTOR(1'b1), .TAG_W(DW + 1)) u_vec_th (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m1_vld_ff),
      .in_x      (-z_ff),
      .in_y      (y1_ff),
      .in_z      ('0),
      .in_tag    ({x1_ff, degen}),
      .out_valid (v1_vld),
      .out_x     (v1_mag),
      .out_y     (),
      .out_z     (v1_ang),
      .out_tag   (v1_tag)
   );

   // rho
   logic                   m2_vld_ff;
   logic signed [DW-1:0]   rho_ff, x1b_ff;
   logic [ANG_W-1:0]       th2_ff;
   logic                   degb_ff;
   logic signed [2*DW-1:0] prho;

   assign prho = (2*DW)'(v1_mag) * (2*DW)'(GAIN_Q30);

   always_ff @(posedge clock) begin
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else if (en) begin
         m2_vld_ff <= v1_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rho_ff  <= prho[30 +: DW];
         th2_ff  <= v1_ang[ANG_W-1:0];
         x1b_ff  <= $signed(v1_tag[DW:1]);
         degb_ff <= v1_tag[0];
      end
   end

   // ph2 = atan2(rho, -x1), alongside sin/cos of th2
   logic                 v2_vld;
   logic signed [DW-1:0] v2_ang, c2, s2;
   logic                 v2_degen;

   dfem_cordic #(.VECTOR(1'b1), .TAG_W(1)) u_vec_ph (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m2_vld_ff),
      .in_x      (-x1b_ff),
      .in_y      (rho_ff),
      .in_z      ('0),
      .in_tag    (degb_ff),
      .out_valid (v2_vld),
      .out_x     (),
      .out_y     (),
      .out_z     (v2_ang),
      .out_tag   (v2_degen)
   );

   dfem_cordic #(.VECTOR(1'b0), .TAG_W(1)) u_sc_th (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (m2_vld_ff),
      .in_x      (GAIN_Q30),
      .in_y      ('0),
      .in_z      (DW'($signed(th2_ff))),
      .in_tag    (1'b0),
      .out_valid (),
      .out_x     (c2),
      .out_y     (s2),
      .out_z     (),
      .out_tag   ()
   );

   // lens pick and radius angle
   logic [ANG_W-1:0]     a2, ph2, d_in;
   logic                 right_in;
   logic                 d_vld_ff, d_right_ff;
   logic [ANG_W-1:0]     d_ff;
   logic signed [DW-1:0] d_c2_ff, d_s2_ff;

   assign a2 = v2_ang[ANG_W-1:0];

   always_comb begin
      if (a2 >= ANG_3QUARTER) begin
         ph2 = '0;
      end else if (a2 > ANG_HALF) begin
         ph2 = ANG_HALF;
      end else begin
         ph2 = a2;
      end
      right_in = ph2 < ANG_QUARTER;
      d_in     = right_in ? ph2 : ANG_HALF - ph2;
      if (v2_degen) begin
         d_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_vld_ff <= 1'b0;
      end else if (en) begin
         d_vld_ff <= v2_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff       <= d_in;
         d_right_ff <= right_in;
         d_c2_ff    <= c2;
         d_s2_ff    <= s2;
      end
   end

   // radius in 2^-18 pixel
   logic                    t_vld_ff, t_right_ff;
   logic [TW-1:0]           t_ff;
   logic signed [DW-1:0]    t_c2_ff, t_s2_ff;
   logic [RQ_W+ANG_W-1:0]   tprod;

   assign tprod = (RQ_W+ANG_W)'(rq_ff) * (RQ_W+ANG_W)'(d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (en) begin
         t_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t_ff       <= tprod[30 +: TW];
         t_right_ff <= d_right_ff;
         t_c2_ff    <= d_c2_ff;
         t_s2_ff    <= d_s2_ff;
      end
   end

   // offsets
   logic                 p_vld_ff, p_right_ff;
   logic signed [PW-1:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (en) begin
         p_vld_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff      <= PW'($signed({1'b0, t_ff})) * PW'(t_c2_ff);
         py_ff      <= PW'($signed({1'b0, t_ff})) * PW'(t_s2_ff);
         p_right_ff <= t_right_ff;
      end
   end

   // round, place on circle, saturate
   function automatic logic [OUT_W-1:0] clamp_out(input logic signed [SW-1:0] v);
      logic [OUT_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > $signed(SW'(OUT_MAX))) begin
         r = OUT_MAX;
      end else begin
         r = v[OUT_W-1:0];
      end
      return r;
   endfunction

   logic [CW-1:0]        wq, cq, c3q;
   logic signed [PW-1:0] rnd, offx_full, offy_full;
   logic signed [SW-1:0] offx, offy, sx, sy;
   rsp_type              o_in;
   rsp_type              o_data_ff;
   logic                 o_vld_ff;

   assign wq  = {w_eff, {FRAC_BITS{1'b0}}};
   assign cq  = wq >> 2;
   assign c3q = wq - cq;
   assign rnd = $signed(PW'(1) << (SHIFT - 1));

   always_comb begin
      offx_full = (px_ff + rnd) >>> SHIFT;
      offy_full = (py_ff + rnd) >>> SHIFT;
      offx      = offx_full[SW-1:0];
      offy      = offy_full[SW-1:0];
      if (p_right_ff) begin
         sx = $signed(SW'(c3q)) - offx;
      end else begin
         sx = $signed(SW'(cq)) + offx;
      end
      sy                = $signed(SW'(cq)) + offy;
      o_in.src_x        = clamp_out(sx);
      o_in.src_y        = clamp_out(sy);
      o_in.lens_select  = p_right_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_vld_ff <= 1'b0;
      end else if (en) begin
         o_vld_ff <= p_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_data_ff <= o_in;
      end
   end

   // two-entry output buffer
   rsp_type    buf_ff [2];
   logic       rd_ptr_ff;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop, wr_ptr;

   assign en     = cnt_ff != 2'd2;
   assign push   = o_vld_ff & en;
   assign pop    = rsp_ch.valid & rsp_ch.ready;
   assign wr_ptr = rd_ptr_ff ^ (cnt_ff != 2'd0);
   assign cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= 2'd0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         rd_ptr_ff <= rd_ptr_ff ^ pop;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr] <= o_data_ff;
      end
   end

   assign rsp_ch.valid       = cnt_ff != 2'd0;
   assign rsp_ch.src_x       = buf_ff[rd_ptr_ff].src_x;
   assign rsp_ch.src_y       = buf_ff[rd_ptr_ff].src_y;
   assign rsp_ch.lens_select = buf_ff[rd_ptr_ff].lens_select;

endmodule

### hdl/dfem_div.sv
module dfem_div import dfem_pkg::*; #(
   parameter int DIV_W = 13
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic [DEST_X_W-1:0] in_num_x,
   input  logic [DEST_X_W-1:0] in_num_y,
   input  logic [DIV_W-1:0]    divisor,
   output logic                out_valid,
   output logic [ANG_W-1:0]    out_quo_x,
   output logic [ANG_W-1:0]    out_quo_y
);

   logic                vld_ff [DIV_STAGES];
   logic [DIV_W-1:0]    rem_ff [2][DIV_STAGES];
   logic [DIV_BITS-1:0] nq_ff  [2][DIV_STAGES];
   logic [DEST_X_W-1:0] num    [2];

   assign num[0] = in_num_x;
   assign num[1] = in_num_y;

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic vld_src;
      if (s == 0) begin : g_first
         assign vld_src = in_valid;
      end else begin : g_next
         assign vld_src = vld_ff[s-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DIV_W-1:0]    rem_src;
         logic [DIV_BITS-1:0] nq_src;
         logic [DIV_W-1:0]    rem_in;
         logic [DIV_BITS-1:0] nq_in;

         if (s == 0) begin : g_first
            assign rem_src = '0;
            assign nq_src  = {num[l], {ANG_W{1'b0}}};
         end else begin : g_next
            assign rem_src = rem_ff[l][s-1];
            assign nq_src  = nq_ff[l][s-1];
         end

         always_comb begin
            logic [DIV_W:0] r2;
            rem_in = rem_src;
            nq_in  = nq_src;
            for (int b = 0; b < DIV_PER_STAGE; b++) begin
               r2 = {rem_in, nq_in[DIV_BITS-1]};
               if (r2 >= {1'b0, divisor}) begin
                  rem_in = DIV_W'(r2 - {1'b0, divisor});
                  nq_in  = {nq_in[DIV_BITS-2:0], 1'b1};
               end else begin
                  rem_in = r2[DIV_W-1:0];
                  nq_in  = {nq_in[DIV_BITS-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[l][s] <= rem_in;
               nq_ff[l][s]  <= nq_in;
            end
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign out_quo_x = nq_ff[0][DIV_STAGES-1][ANG_W-1:0];
   assign out_quo_y = nq_ff[1][DIV_STAGES-1][ANG_W-1:0];

endmodule

### hdl/dfem_cordic.sv
module dfem_cordic import dfem_pkg::*; #(
   parameter bit VECTOR = 1'b0,
   parameter int TAG_W  = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] in_x,
   input  logic signed [DW-1:0] in_y,
   input  logic signed [DW-1:0] in_z,
   input  logic [TAG_W-1:0]     in_tag,
   output logic                 out_valid,
   output logic signed [DW-1:0] out_x,
   output logic signed [DW-1:0] out_y,
   output logic signed [DW-1:0] out_z,
   output logic [TAG_W-1:0]     out_tag
);

   logic                 vld_ff  [STEPS+1];
   logic signed [DW-1:0] x_ff    [STEPS+1];
   logic signed [DW-1:0] y_ff    [STEPS+1];
   logic signed [DW-1:0] z_ff    [STEPS+1];
   logic [TAG_W-1:0]     tag_ff  [STEPS+1];
   logic                 flip_ff [STEPS+1];

   logic                 out_vld_ff;
   logic signed [DW-1:0] out_x_ff, out_y_ff, out_z_ff;
   logic [TAG_W-1:0]     out_tag_ff;

   logic signed [DW-1:0] x0_in, y0_in, z0_in;
   logic                 flip0_in;

   // range reduction / half-plane fold
   always_comb begin
      x0_in    = in_x;
      y0_in    = in_y;
      z0_in    = in_z;
      flip0_in = 1'b0;
      if (VECTOR) begin
         if (in_x < 0) begin
            x0_in = -in_x;
            y0_in = -in_y;
            z0_in = in_z + HALF_TURN;
         end
      end else begin
         if (in_z > QUARTER_TURN) begin
            z0_in    = in_z - HALF_TURN;
            flip0_in = 1'b1;
         end else if (in_z < -QUARTER_TURN) begin
            z0_in    = in_z + HALF_TURN;
            flip0_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]    <= x0_in;
         y_ff[0]    <= y0_in;
         z_ff[0]    <= z0_in;
         tag_ff[0]  <= in_tag;
         flip_ff[0] <= flip0_in;
      end
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_iter
      localparam int I = k - 1;
      logic signed [DW-1:0] xn, yn, zn;

      always_comb begin
         if (VECTOR) begin
            if (y_ff[k-1] >= 0) begin
               xn = x_ff[k-1] + (y_ff[k-1] >>> I);
               yn = y_ff[k-1] - (x_ff[k-1] >>> I);
               zn = z_ff[k-1] + atan_turn(I);
            end else begin
               xn = x_ff[k-1] - (y_ff[k-1] >>> I);
               yn = y_ff[k-1] + (x_ff[k-1] >>> I);
               zn = z_ff[k-1] - atan_turn(I);
            end
         end else begin
            if (z_ff[k-1] >= 0) begin
               xn = x_ff[k-1] - (y_ff[k-1] >>> I);
               yn = y_ff[k-1] + (x_ff[k-1] >>> I);
               zn = z_ff[k-1] - atan_turn(I);
            end else begin
               xn = x_ff[k-1] + (y_ff[k-1] >>> I);
               yn = y_ff[k-1] - (x_ff[k-1] >>> I);
               zn = z_ff[k-1] + atan_turn(I);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[k]    <= xn;
            y_ff[k]    <= yn;
            z_ff[k]    <= zn;
            tag_ff[k]  <= tag_ff[k-1];
            flip_ff[k] <= flip_ff[k-1];
         end
      end
   end

   // undo the half-turn fold
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff   <= flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
         out_y_ff   <= flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
         out_z_ff   <= z_ff[STEPS];
         out_tag_ff <= tag_ff[STEPS];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_z     = out_z_ff;
   assign out_tag   = out_tag_ff;

endmodule

### hdl/dfem_checker.sv
module dfem_checker import dfem_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [OUT_W-1:0] rsp_src_x,
   input logic [OUT_W-1:0] rsp_src_y,
   input logic             rsp_lens_select
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_x) &&
         $stable(rsp_src_y) && $stable(rsp_lens_select))
      else $error("rsp changed while stalled");

   a_full_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req blocked with no pending rsp");

   a_full_after_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("req blocked without rsp stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind dual_fisheye_equirect_map dfem_checker u_dfem_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_src_x       (rsp_ch.src_x),
   .rsp_src_y       (rsp_ch.src_y),
   .rsp_lens_select (rsp_ch.lens_select)
);
